[rtl/rbsi_pkg.sv]
package rbsi_pkg;

   localparam int FRAC_BITS = 16;
   localparam int WORD_W    = 32;
   localparam int DIV_W     = WORD_W + FRAC_BITS;
   localparam int DIST_W    = WORD_W + 1;
   localparam int SQ_W      = 2 * WORD_W;
   localparam int ROOT_W    = WORD_W;
   localparam int SQREM_W   = ROOT_W + 2;
   localparam int FACE_W    = 3;
   localparam int IN_W      = 12 * WORD_W;
   localparam int OUT_W     = ((5 * WORD_W + FACE_W + 7) / 8) * 8;

   typedef enum logic [FACE_W-1:0] {
      FACE_POS_X,
      FACE_NEG_X,
      FACE_POS_Y,
      FACE_NEG_Y,
      FACE_POS_Z,
      FACE_NEG_Z
   } face_type;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic [WORD_W-1:0]        uword_type;
   typedef logic [DIV_W-1:0]         quot_type;

   typedef struct packed {
      word_type [2:0] org;
      word_type [2:0] dir;
      word_type [2:0] bmin;
      word_type [2:0] bmax;
   } ray_box_type;

   typedef struct packed {
      ray_box_type     rb;
      uword_type [2:0] dmag;
      logic [2:0]      zero_dir;
      logic [2:0]      in_slab;
      logic [2:0]      neg_lo;
      logic [2:0]      neg_hi;
   } ctx_type;

   // six divider lanes (lo/hi per axis) plus one square-root lane
   typedef struct packed {
      ctx_type              ctx;
      quot_type [5:0]       nq;
      uword_type [5:0]      rem;
      logic [SQ_W-1:0]      sqv;
      logic [SQREM_W-1:0]   sqrem;
      uword_type            root;
   } iter_type;

   typedef struct packed {
      logic      hit;
      word_type  hit_x;
      word_type  hit_y;
      word_type  hit_z;
      uword_type hit_time;
      uword_type hit_depth;
      face_type  hit_face;
   } result_type;

endpackage

[rtl/rbsi_prep.sv]
module rbsi_prep (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  rbsi_pkg::ray_box_type  in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output rbsi_pkg::iter_type     out_data
);
   import rbsi_pkg::*;

   logic                  s1_vld_ff;
   logic                  s2_vld_ff;
   logic                  rdy1;
   logic                  rdy2;
   ctx_type               s1_ctx_ff;
   ctx_type               s1_ctx_in;
   logic [2:0][SQ_W-1:0]  s1_sq_ff;
   logic [2:0][SQ_W-1:0]  s1_sq_in;
   iter_type              s2_data_ff;
   iter_type              s2_data_in;

   assign rdy2      = !s2_vld_ff || out_ready;
   assign rdy1      = !s1_vld_ff || rdy2;
   assign in_ready  = rdy1;
   assign out_valid = s2_vld_ff;
   assign out_data  = s2_data_ff;

   // stage 1: slab numerator signs, |dir|, dir squared
   always_comb begin
      logic signed [WORD_W:0] num_lo;
      logic signed [WORD_W:0] num_hi;
      logic                   dneg;
      s1_ctx_in    = '0;
      s1_ctx_in.rb = in_data;
      for (int a = 0; a < 3; a++) begin
         num_lo = $signed({in_data.bmin[a][WORD_W-1], in_data.bmin[a]})
                - $signed({in_data.org[a][WORD_W-1], in_data.org[a]});
         num_hi = $signed({in_data.bmax[a][WORD_W-1], in_data.bmax[a]})
                - $signed({in_data.org[a][WORD_W-1], in_data.org[a]});
         dneg   = in_data.dir[a][WORD_W-1];
         s1_ctx_in.dmag[a]     = dneg ? uword_type'(-in_data.dir[a])
                                      : uword_type'(in_data.dir[a]);
         s1_ctx_in.zero_dir[a] = (in_data.dir[a] == '0);
         s1_ctx_in.in_slab[a]  = ($signed(in_data.org[a]) >= $signed(in_data.bmin[a]))
                              && ($signed(in_data.org[a]) <= $signed(in_data.bmax[a]));
         s1_ctx_in.neg_lo[a]   = (num_lo != '0) && (num_lo[WORD_W] != dneg);
         s1_ctx_in.neg_hi[a]   = (num_hi != '0) && (num_hi[WORD_W] != dneg);
         s1_sq_in[a] = SQ_W'(s1_ctx_in.dmag[a]) * SQ_W'(s1_ctx_in.dmag[a]);
      end
   end

   // stage 2: sum of squares, dividend magnitudes, lane init
   always_comb begin
      logic signed [WORD_W:0] num;
      logic [WORD_W:0]        mag;
      s2_data_in       = '0;
      s2_data_in.ctx   = s1_ctx_ff;
      s2_data_in.sqv   = s1_sq_ff[0] + s1_sq_ff[1] + s1_sq_ff[2];
      s2_data_in.sqrem = '0;
      s2_data_in.root  = '0;
      for (int a = 0; a < 3; a++) begin
         for (int k = 0; k < 2; k++) begin
            num = (k == 0)
                ? $signed({s1_ctx_ff.rb.bmin[a][WORD_W-1], s1_ctx_ff.rb.bmin[a]})
                  - $signed({s1_ctx_ff.rb.org[a][WORD_W-1], s1_ctx_ff.rb.org[a]})
                : $signed({s1_ctx_ff.rb.bmax[a][WORD_W-1], s1_ctx_ff.rb.bmax[a]})
                  - $signed({s1_ctx_ff.rb.org[a][WORD_W-1], s1_ctx_ff.rb.org[a]});
            mag = num[WORD_W] ? (WORD_W+1)'(-num) : (WORD_W+1)'(num);
            s2_data_in.nq[2*a+k]  = {mag[WORD_W-1:0], {FRAC_BITS{1'b0}}};
            s2_data_in.rem[2*a+k] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         if (rdy1) s1_vld_ff <= in_valid;
         if (rdy2) s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_ctx_ff <= s1_ctx_in;
         s1_sq_ff  <= s1_sq_in;
      end
      if (rdy2) s2_data_ff <= s2_data_in;
   end

endmodule

[rtl/rbsi_iter.sv]
module rbsi_iter (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  rbsi_pkg::iter_type  in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output rbsi_pkg::iter_type  out_data
);
   import rbsi_pkg::*;

   // one quotient bit per lane per stage; one root bit in the first ROOT_W stages
   function automatic iter_type step(input iter_type x, input logic root_en);
      iter_type            y;
      logic [WORD_W:0]     tmp;
      logic [WORD_W:0]     den;
      logic [SQREM_W+1:0]  r2;
      logic [SQREM_W-1:0]  trial;
      y = x;
      for (int a = 0; a < 3; a++) begin
         for (int k = 0; k < 2; k++) begin
            tmp = {x.rem[2*a+k], x.nq[2*a+k][DIV_W-1]};
            den = {1'b0, x.ctx.dmag[a]};
            if (tmp >= den) begin
               y.rem[2*a+k] = WORD_W'(tmp - den);
               y.nq[2*a+k]  = {x.nq[2*a+k][DIV_W-2:0], 1'b1};
            end else begin
               y.rem[2*a+k] = tmp[WORD_W-1:0];
               y.nq[2*a+k]  = {x.nq[2*a+k][DIV_W-2:0], 1'b0};
            end
         end
      end
      if (root_en) begin
         r2    = {x.sqrem, x.sqv[SQ_W-1 -: 2]};
         trial = {x.root, 2'b01};
         if (r2 >= {2'b00, trial}) begin
            y.sqrem = SQREM_W'(r2 - {2'b00, trial});
            y.root  = {x.root[ROOT_W-2:0], 1'b1};
         end else begin
            y.sqrem = r2[SQREM_W-1:0];
            y.root  = {x.root[ROOT_W-2:0], 1'b0};
         end
         y.sqv = {x.sqv[SQ_W-3:0], 2'b00};
      end
      return y;
   endfunction

   logic [DIV_W-1:0] vld_ff;
   logic [DIV_W:0]   rdy;
   iter_type         st_ff [DIV_W];
   iter_type         st_in [DIV_W];

   assign rdy[DIV_W] = out_ready;
   assign in_ready   = rdy[0];
   assign out_valid  = vld_ff[DIV_W-1];
   assign out_data   = st_ff[DIV_W-1];

   for (genvar s = 0; s < DIV_W; s++) begin : g_stage
      assign rdy[s] = !vld_ff[s] || rdy[s+1];
      if (s == 0) begin : g_first
         assign st_in[s] = step(in_data, 1'b1);
         always_ff @(posedge clock) begin
            if (reset) vld_ff[s] <= 1'b0;
            else if (rdy[s]) vld_ff[s] <= in_valid;
         end
      end else begin : g_rest
         assign st_in[s] = step(st_ff[s-1], 1'(s < ROOT_W));
         always_ff @(posedge clock) begin
            if (reset) vld_ff[s] <= 1'b0;
            else if (rdy[s]) vld_ff[s] <= vld_ff[s-1];
         end
      end
      always_ff @(posedge clock) begin
         if (rdy[s]) st_ff[s] <= st_in[s];
      end
   end

endmodule

[rtl/rbsi_back.sv]
module rbsi_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  rbsi_pkg::iter_type    in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output rbsi_pkg::result_type  out_data
);
   import rbsi_pkg::*;

   localparam int NB    = 7;
   localparam int OFF_W = SQ_W - FRAC_BITS;
   localparam int SUM_W = OFF_W + 2;

   typedef struct packed {
      ray_box_type     rb;
      uword_type [2:0] dmag;
      uword_type       len;
   } carry_type;

   logic [NB-1:0] vld_ff;
   logic [NB-1:0] vld_src;
   logic [NB:0]   rdy;

   // A: per-axis entry/exit
   carry_type      a_cr_ff,   a_cr_in;
   logic [2:0]     a_ok_ff,   a_ok_in;
   logic [2:0]     a_inf_ff,  a_inf_in;
   quot_type [2:0] a_tmin_ff, a_tmin_in;
   quot_type [2:0] a_tmax_ff, a_tmax_in;
   // B: combine axes
   carry_type      b_cr_ff,   b_cr_in;
   logic           b_ok_ff,   b_ok_in;
   quot_type       b_enter_ff, b_enter_in;
   quot_type       b_exit_ff,  b_exit_in;
   logic           b_inf_ff,   b_inf_in;
   // C: decision and saturated time
   carry_type      c_cr_ff,   c_cr_in;
   logic           c_hit_ff,  c_hit_in;
   uword_type      c_t_ff,    c_t_in;
   // D: products
   ray_box_type          d_rb_ff,   d_rb_in;
   logic                 d_hit_ff,  d_hit_in;
   uword_type            d_t_ff,    d_t_in;
   logic [2:0][SQ_W-1:0] d_prod_ff, d_prod_in;
   logic [SQ_W-1:0]      d_dprod_ff, d_dprod_in;
   // E: hit point and depth
   ray_box_type    e_rb_ff,   e_rb_in;
   logic           e_hit_ff,  e_hit_in;
   uword_type      e_t_ff,    e_t_in;
   word_type [2:0] e_p_ff,    e_p_in;
   uword_type      e_dep_ff,  e_dep_in;
   // F: face distances
   logic                   f_hit_ff,  f_hit_in;
   uword_type              f_t_ff,    f_t_in;
   word_type [2:0]         f_p_ff,    f_p_in;
   uword_type              f_dep_ff,  f_dep_in;
   logic [5:0][DIST_W-1:0] f_dist_ff, f_dist_in;
   // G: face pick, miss zeroing
   result_type     g_res_ff,  g_res_in;

   assign vld_src   = {vld_ff[NB-2:0], in_valid};
   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[NB-1];
   assign out_data  = g_res_ff;

   always_comb begin
      rdy[NB] = out_ready;
      for (int k = NB - 1; k >= 0; k--) rdy[k] = !vld_ff[k] || rdy[k+1];
   end

   always_comb begin
      quot_type ql, qh, cl, ch;
      logic     nl, nh;
      a_cr_in.rb   = in_data.ctx.rb;
      a_cr_in.dmag = in_data.ctx.dmag;
      a_cr_in.len  = in_data.root;
      for (int a = 0; a < 3; a++) begin
         ql = in_data.nq[2*a];
         qh = in_data.nq[2*a+1];
         nl = in_data.ctx.neg_lo[a];
         nh = in_data.ctx.neg_hi[a];
         cl = nl ? '0 : ql;
         ch = nh ? '0 : qh;
         if (in_data.ctx.zero_dir[a]) begin
            a_tmin_in[a] = '0;
            a_tmax_in[a] = '0;
            a_inf_in[a]  = 1'b1;
            a_ok_in[a]   = in_data.ctx.in_slab[a];
         end else begin
            a_tmin_in[a] = (cl < ch) ? cl : ch;
            a_tmax_in[a] = nl ? qh : (nh ? ql : ((ql > qh) ? ql : qh));
            a_inf_in[a]  = 1'b0;
            a_ok_in[a]   = !(nl && nh);
         end
      end
   end

   always_comb begin
      quot_type e01, x01;
      logic     i01;
      b_cr_in    = a_cr_ff;
      b_ok_in    = &a_ok_ff;
      e01        = (a_tmin_ff[0] > a_tmin_ff[1]) ? a_tmin_ff[0] : a_tmin_ff[1];
      b_enter_in = (e01 > a_tmin_ff[2]) ? e01 : a_tmin_ff[2];
      // infinite exit loses every minimum
      if (a_inf_ff[0]) begin
         x01 = a_tmax_ff[1];
         i01 = a_inf_ff[1];
      end else if (a_inf_ff[1] || a_tmax_ff[0] < a_tmax_ff[1]) begin
         x01 = a_tmax_ff[0];
         i01 = 1'b0;
      end else begin
         x01 = a_tmax_ff[1];
         i01 = 1'b0;
      end
      if (i01) begin
         b_exit_in = a_tmax_ff[2];
         b_inf_in  = a_inf_ff[2];
      end else if (a_inf_ff[2] || x01 < a_tmax_ff[2]) begin
         b_exit_in = x01;
         b_inf_in  = 1'b0;
      end else begin
         b_exit_in = a_tmax_ff[2];
         b_inf_in  = 1'b0;
      end
   end

   always_comb begin
      quot_type tsel;
      logic     tinf;
      c_cr_in  = b_cr_ff;
      c_hit_in = b_ok_ff && (b_inf_ff || b_enter_ff <= b_exit_ff);
      // entry at zero: origin inside, report the exit
      if (b_enter_ff == '0) begin
         tsel = b_exit_ff;
         tinf = b_inf_ff;
      end else begin
         tsel = b_enter_ff;
         tinf = 1'b0;
      end
      if (tinf || |tsel[DIV_W-1:WORD_W]) c_t_in = '1;
      else c_t_in = tsel[WORD_W-1:0];
   end

   always_comb begin
      d_rb_in  = c_cr_ff.rb;
      d_hit_in = c_hit_ff;
      d_t_in   = c_t_ff;
      for (int a = 0; a < 3; a++) begin
         d_prod_in[a] = SQ_W'(c_cr_ff.dmag[a]) * SQ_W'(c_t_ff);
      end
      d_dprod_in = SQ_W'(c_cr_ff.len) * SQ_W'(c_t_ff);
   end

   always_comb begin
      logic [OFF_W-1:0]        off;
      logic signed [SUM_W-1:0] so;
      logic signed [SUM_W-1:0] sum;
      logic [SQ_W-1:0]         dsh;
      e_rb_in  = d_rb_ff;
      e_hit_in = d_hit_ff;
      e_t_in   = d_t_ff;
      for (int a = 0; a < 3; a++) begin
         off = d_prod_ff[a][SQ_W-1:FRAC_BITS];
         so  = $signed(SUM_W'(off));
         if (d_rb_ff.dir[a][WORD_W-1]) so = -so;
         sum = SUM_W'(d_rb_ff.org[a]) + so;
         if (sum[SUM_W-1:WORD_W-1] == '0 || sum[SUM_W-1:WORD_W-1] == '1) begin
            e_p_in[a] = sum[WORD_W-1:0];
         end else if (sum[SUM_W-1]) begin
            e_p_in[a] = {1'b1, {(WORD_W-1){1'b0}}};
         end else begin
            e_p_in[a] = {1'b0, {(WORD_W-1){1'b1}}};
         end
      end
      dsh = d_dprod_ff >> FRAC_BITS;
      e_dep_in = (|dsh[SQ_W-1:WORD_W]) ? '1 : dsh[WORD_W-1:0];
   end

   always_comb begin
      logic signed [WORD_W:0] dh;
      logic signed [WORD_W:0] dl;
      f_hit_in = e_hit_ff;
      f_t_in   = e_t_ff;
      f_p_in   = e_p_ff;
      f_dep_in = e_dep_ff;
      for (int a = 0; a < 3; a++) begin
         dh = $signed({e_rb_ff.bmax[a][WORD_W-1], e_rb_ff.bmax[a]})
            - $signed({e_p_ff[a][WORD_W-1], e_p_ff[a]});
         dl = $signed({e_rb_ff.bmin[a][WORD_W-1], e_rb_ff.bmin[a]})
            - $signed({e_p_ff[a][WORD_W-1], e_p_ff[a]});
         f_dist_in[2*a]   = dh[WORD_W] ? DIST_W'(-dh) : DIST_W'(dh);
         f_dist_in[2*a+1] = dl[WORD_W] ? DIST_W'(-dl) : DIST_W'(dl);
      end
   end

   always_comb begin
      logic [DIST_W-1:0] best;
      logic [FACE_W-1:0] face;
      best = f_dist_ff[0];
      face = FACE_POS_X;
      for (int i = 1; i < 6; i++) begin
         if (f_dist_ff[i] < best) begin
            best = f_dist_ff[i];
            face = FACE_W'(i);
         end
      end
      g_res_in = '0;
      if (f_hit_ff) begin
         g_res_in.hit       = 1'b1;
         g_res_in.hit_x     = f_p_ff[0];
         g_res_in.hit_y     = f_p_ff[1];
         g_res_in.hit_z     = f_p_ff[2];
         g_res_in.hit_time  = f_t_ff;
         g_res_in.hit_depth = f_dep_ff;
         g_res_in.hit_face  = face_type'(face);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NB; k++) begin
            if (rdy[k]) vld_ff[k] <= vld_src[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         a_cr_ff   <= a_cr_in;
         a_ok_ff   <= a_ok_in;
         a_inf_ff  <= a_inf_in;
         a_tmin_ff <= a_tmin_in;
         a_tmax_ff <= a_tmax_in;
      end
      if (rdy[1]) begin
         b_cr_ff    <= b_cr_in;
         b_ok_ff    <= b_ok_in;
         b_enter_ff <= b_enter_in;
         b_exit_ff  <= b_exit_in;
         b_inf_ff   <= b_inf_in;
      end
      if (rdy[2]) begin
         c_cr_ff  <= c_cr_in;
         c_hit_ff <= c_hit_in;
         c_t_ff   <= c_t_in;
      end
      if (rdy[3]) begin
         d_rb_ff    <= d_rb_in;
         d_hit_ff   <= d_hit_in;
         d_t_ff     <= d_t_in;
         d_prod_ff  <= d_prod_in;
         d_dprod_ff <= d_dprod_in;
      end
      if (rdy[4]) begin
         e_rb_ff  <= e_rb_in;
         e_hit_ff <= e_hit_in;
         e_t_ff   <= e_t_in;
         e_p_ff   <= e_p_in;
         e_dep_ff <= e_dep_in;
      end
      if (rdy[5]) begin
         f_hit_ff  <= f_hit_in;
         f_t_ff    <= f_t_in;
         f_p_ff    <= f_p_in;
         f_dep_ff  <= f_dep_in;
         f_dist_ff <= f_dist_in;
      end
      if (rdy[6]) g_res_ff <= g_res_in;
   end

endmodule

[rtl/ray_box_slab_intersection.sv]
// Ray versus axis-aligned box, slab test, fixed point Q16.16.
//
// Input channel (req_): one transaction carries a ray origin, a direction and
// the box corners. Result channel (rsp_): one transaction per input, with the
// hit flag on rsp_tuser and hit point, time, depth and nearest face on
// rsp_tdata; on a miss every data field is zero.
//
// The path from an accepted request to its result runs through 2 setup
// stages, 48 stages of the bit-per-stage slab dividers (the square root of
// |dir|^2 runs alongside in the first 32 of them) and 7 stages of slab
// combine, multiply, saturate and face select.
// Throughput is one transaction per cycle while rsp_tready stays high.
//
// Reset (synchronous, active high) drops every transaction in flight.
// When the receiver holds rsp_tready low the result register holds; each
// stage advances into a free slot of the next, so bubbles close up and
// req_tready stays high until the whole pipeline is full.
module ray_box_slab_intersection (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // origin x,y,z; dir x,y,z; box_min x,y,z; box_max x,y,z (32 bits each)
   input  logic [rbsi_pkg::IN_W-1:0]     req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // hit_x, hit_y, hit_z, hit_time, hit_depth (32 bits each), hit_face (3), zero fill
   output logic [rbsi_pkg::OUT_W-1:0]    rsp_tdata,
   // hit
   output logic                          rsp_tuser
);
   import rbsi_pkg::*;

   ray_box_type req_rb;
   logic        prep_vld, prep_rdy;
   iter_type    prep_data;
   logic        iter_vld, iter_rdy;
   iter_type    iter_data;
   result_type  res;

   // unpack the request fields, lowest bits first
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         req_rb.org[a]  = req_tdata[WORD_W*a +: WORD_W];
         req_rb.dir[a]  = req_tdata[WORD_W*(3+a) +: WORD_W];
         req_rb.bmin[a] = req_tdata[WORD_W*(6+a) +: WORD_W];
         req_rb.bmax[a] = req_tdata[WORD_W*(9+a) +: WORD_W];
      end
   end

   rbsi_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_rb),
      .out_valid (prep_vld),
      .out_ready (prep_rdy),
      .out_data  (prep_data)
   );

   rbsi_iter u_iter (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_vld),
      .in_ready  (prep_rdy),
      .in_data   (prep_data),
      .out_valid (iter_vld),
      .out_ready (iter_rdy),
      .out_data  (iter_data)
   );

   rbsi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (iter_vld),
      .in_ready  (iter_rdy),
      .in_data   (iter_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (res)
   );

   // pack the result fields, lowest bits first
   assign rsp_tuser = res.hit;
   assign rsp_tdata = {{(OUT_W - 5*WORD_W - FACE_W){1'b0}},
                       res.hit_face, res.hit_depth, res.hit_time,
                       res.hit_z, res.hit_y, res.hit_x};

endmodule

[rtl/rbsi_check.sv]
module rbsi_check (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [rbsi_pkg::OUT_W-1:0]  rsp_tdata,
   input logic                        rsp_tuser
);
   import rbsi_pkg::*;

   localparam int FACE_LSB = 5 * WORD_W;

   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("miss carries nonzero data");

   a_face_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[FACE_LSB +: FACE_W] <= FACE_NEG_Z)
      else $error("face code out of range");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind ray_box_slab_intersection rbsi_check u_check (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
